### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and gated by an
// active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/saws_pkg.sv
// ----------------------------------------------------------------------------
// Self-avoiding walk sampler package
// Field widths and fixed sizes shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package saws_pkg;

    localparam int CHOICE_W = 2;   // direction pick per input word
    localparam int SQ_W     = 13;  // squared end-to-end distance
    localparam int WLEN_W   = 7;   // walk length register
    localparam int EPOCH_W  = 8;   // walk tag kept in each lattice site

endpackage

`default_nettype wire

### src/saws_in_if.sv
// ----------------------------------------------------------------------------
// Sampler input channel
// One direction choice per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface saws_in_if;
    import saws_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHOICE_W-1:0] choice;

    modport source (output valid, output choice, input ready);
    modport sink   (input valid, input choice, output ready);
endinterface

`default_nettype wire

### src/saws_out_if.sv
// ----------------------------------------------------------------------------
// Sampler result channel
// One word per finished walk: accept flag and squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

interface saws_out_if;
    import saws_pkg::*;

    logic            valid;
    logic            ready;
    logic            accepted;
    logic [SQ_W-1:0] sq_distance;

    modport source (output valid, output accepted, output sq_distance, input ready);
    modport sink   (input valid, input accepted, input sq_distance, output ready);
endinterface

`default_nettype wire

### src/self_avoiding_walk_sampler.sv
// ----------------------------------------------------------------------------
// Self-avoiding walk sampler
// Grows 2D self-avoiding walks on a square lattice by simple sampling, one
// step per input word, and reports accept flag and squared distance per walk.
// ----------------------------------------------------------------------------
//  channel    dir  payload                       handshake
//  i_item     in   choice[1:0]                   valid / ready
//  o_result   out  accepted, sq_distance[12:0]   valid / ready
//  i_cfg_*    in   walk_length[6:0]              write enable, no wait
//
//  A step is a lattice read, then check and write-back of the site.
//  The final step of a completed walk adds the S_SQX and S_SQY states for the distance square.
//  Each site holds a walk tag; after reset and after every 255th walk the tags
//  are swept to zero, site by site, with i_item.ready low.
//  The check cycle waits while an earlier result word is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module self_avoiding_walk_sampler #(
    parameter int MAX_LEN = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [saws_pkg::WLEN_W-1:0]   i_cfg_wdata,
    saws_in_if.sink                      i_item,
    saws_out_if.source                   o_result
);
    import saws_pkg::*;

    localparam int SIDE     = 2 * MAX_LEN + 2;
    localparam int CENTRE   = MAX_LEN + 1;
    localparam int CELLS    = SIDE * SIDE;
    localparam int CORD_W   = $clog2(SIDE);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int STEP_W   = $clog2(MAX_LEN + 1);
    localparam int LEN_W    = (STEP_W > WLEN_W) ? STEP_W : WLEN_W;
    localparam int SUM_W    = 2 * CORD_W + 1;
    localparam int CTR_ADDR = CENTRE * SIDE + CENTRE;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_SQX, S_SQY} t_state;
    typedef enum logic [1:0] {DIR_PX, DIR_MX, DIR_PY, DIR_MY} t_dir;

    // lattice: one walk tag per site, a site is taken when its tag is current
    logic [EPOCH_W-1:0] r_lattice [CELLS];
    logic [EPOCH_W-1:0] r_rdata;

    t_state             r_state;
    logic [WLEN_W-1:0]  r_walk_length;
    logic [EPOCH_W-1:0] r_epoch;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_active;
    logic [CORD_W-1:0]  r_pos_x, r_pos_y;
    t_dir               r_last_dir;
    logic [STEP_W-1:0]  r_steps;
    logic               r_first;
    t_dir               r_dir;
    logic [CORD_W-1:0]  r_nx, r_ny;
    logic [ADDR_W-1:0]  r_addr;
    logic [CORD_W-1:0]  r_dx, r_dy;
    logic [SUM_W-1:0]   r_acc;
    logic               r_out_valid;
    logic               r_out_accepted;
    logic [SQ_W-1:0]    r_out_sq;

    logic               acc;
    logic               slot_free;
    logic               out_load;
    logic               taken;
    logic [1:0]         pick;
    logic [1:0]         base;
    t_dir               dir_new;
    logic [CORD_W-1:0]  nx, ny;
    logic [ADDR_W-1:0]  addr_new;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [EPOCH_W-1:0] mem_wdata;
    logic [LEN_W-1:0]   len_ext;
    logic [LEN_W-1:0]   eff_len;
    logic [STEP_W-1:0]  n_steps;
    logic               len_done;
    logic [CORD_W-1:0]  dx_new, dy_new;

    assign i_item.ready         = (r_state == S_IDLE);
    assign acc                  = i_item.valid && (r_state == S_IDLE);
    assign slot_free            = !r_out_valid || o_result.ready;
    // a new result word is loaded this cycle
    assign out_load             = (r_state == S_SQY) ||
                                  ((r_state == S_CHECK) && slot_free && taken);
    assign o_result.valid       = r_out_valid;
    assign o_result.accepted    = r_out_accepted;
    assign o_result.sq_distance = r_out_sq;

    // direction of the next step
    always_comb begin
        pick = (i_item.choice > 2'd2) ? 2'd2 : i_item.choice;
        unique case (r_last_dir)
            DIR_PX:  base = 2'd2;
            DIR_MX:  base = 2'd1;
            DIR_PY:  base = 2'd0;
            DIR_MY:  base = 2'd3;
            default: base = 2'd0;
        endcase
        dir_new = r_active ? t_dir'(2'(base + pick)) : t_dir'(i_item.choice);
    end

    // neighbour site; a new walk starts from the centre
    always_comb begin
        logic [CORD_W-1:0] px, py;
        px = r_active ? r_pos_x : CORD_W'(CENTRE);
        py = r_active ? r_pos_y : CORD_W'(CENTRE);
        nx = px;
        ny = py;
        unique case (dir_new)
            DIR_PX:  nx = px + 1'b1;
            DIR_MX:  nx = px - 1'b1;
            DIR_PY:  ny = py + 1'b1;
            DIR_MY:  ny = py - 1'b1;
            default: nx = px;
        endcase
        addr_new = ADDR_W'(ny) * ADDR_W'(SIDE) + ADDR_W'(nx);
        rd_addr  = acc ? addr_new : r_addr;
    end

    always_comb begin
        taken    = !r_first && (r_rdata == r_epoch);
        len_ext  = LEN_W'(r_walk_length);
        if (len_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_LEN)) begin
            eff_len = LEN_W'(MAX_LEN);
        end else begin
            eff_len = len_ext;
        end
        n_steps  = r_first ? STEP_W'(1) : r_steps + 1'b1;
        len_done = LEN_W'(n_steps) >= eff_len;
        dx_new   = (r_nx >= CORD_W'(CENTRE)) ? r_nx - CORD_W'(CENTRE)
                                             : CORD_W'(CENTRE) - r_nx;
        dy_new   = (r_ny >= CORD_W'(CENTRE)) ? r_ny - CORD_W'(CENTRE)
                                             : CORD_W'(CENTRE) - r_ny;
    end

    // lattice write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_epoch;
        unique case (r_state)
            S_IDLE: begin
                if (acc && !r_active) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(CTR_ADDR);
                end
            end
            S_CHECK: begin
                mem_we = slot_free && !taken;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_lattice[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_lattice[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_walk_length <= WLEN_W'(16);
            r_epoch       <= EPOCH_W'(1);
            r_clr         <= '0;
            r_active      <= 1'b0;
            r_pos_x       <= CORD_W'(CENTRE);
            r_pos_y       <= CORD_W'(CENTRE);
            r_last_dir    <= DIR_PX;
            r_steps       <= '0;
            r_first       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_walk_length <= i_cfg_wdata;
            end
            if (r_out_valid && o_result.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(CELLS - 1)) begin
                        r_epoch <= EPOCH_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_first <= !r_active;
                        r_dir   <= dir_new;
                        r_nx    <= nx;
                        r_ny    <= ny;
                        r_addr  <= addr_new;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // hold until the result word is free
                    if (slot_free) begin
                        if (taken) begin
                            r_active       <= 1'b0;
                            r_out_valid    <= 1'b1;
                            r_out_accepted <= 1'b0;
                            r_out_sq       <= '0;
                            r_clr          <= '0;
                            r_epoch        <= (r_epoch == '1) ? EPOCH_W'(1)
                                                              : r_epoch + 1'b1;
                            r_state        <= (r_epoch == '1) ? S_CLEAR : S_IDLE;
                        end else begin
                            r_pos_x    <= r_nx;
                            r_pos_y    <= r_ny;
                            r_last_dir <= r_dir;
                            r_steps    <= n_steps;
                            if (len_done) begin
                                r_active <= 1'b0;
                                r_dx     <= dx_new;
                                r_dy     <= dy_new;
                                r_state  <= S_SQX;
                            end else begin
                                r_active <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    end
                end
                S_SQX: begin
                    r_acc   <= SUM_W'(r_dx) * SUM_W'(r_dx);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_out_valid    <= 1'b1;
                    r_out_accepted <= 1'b1;
                    r_out_sq       <= SQ_W'(r_acc + SUM_W'(r_dy) * SUM_W'(r_dy));
                    r_clr          <= '0;
                    r_epoch        <= (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + 1'b1;
                    r_state        <= (r_epoch == '1) ? S_CLEAR : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_epoch_live, i_clk, i_rst_n, r_epoch != '0, "walk tag reached zero")
    `ASSERT_IMPLIES(a_result_ends_walk, i_clk, i_rst_n,
        $rose(r_out_valid), !r_active, "result while walk active")
    `ASSERT_IMPLIES(a_abort_zero, i_clk, i_rst_n,
        r_out_valid && !r_out_accepted, r_out_sq == '0, "aborted walk with distance")
    `ASSERT_IMPLIES(a_steps_bound, i_clk, i_rst_n,
        r_active, (r_steps != '0) && (LEN_W'(r_steps) < LEN_W'(MAX_LEN)),
        "active walk past its length")

endmodule

`default_nettype wire
